// ===== rtl/core/ptracl_pkg.sv =====
// Shared constants, codes and types for the pointer acceleration/clamp unit.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package ptracl_pkg;

	// Field and register widths
	localparam int COORD_BITS_DEF = 12;
	localparam int VAL_W          = 16;
	localparam int THR_W          = 15;
	localparam int GAIN_W         = 8;
	localparam int REG_W          = 12;
	localparam int OUT_POS_W      = 12;
	localparam int STEP_W         = 13;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 15;
	localparam int KIND_W         = 2;
	localparam int AXIS_W         = 2;

	// Datapath widths: |delta| - threshold, gain product, signed working width
	localparam int MAG_W  = VAL_W + 1;
	localparam int DIFF_W = VAL_W;
	localparam int PROD_W = DIFF_W + GAIN_W;
	localparam int ACC_W  = PROD_W + 3;

	// Event codes
	localparam logic [KIND_W-1:0] KIND_REL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ABS = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_X   = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y   = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z   = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DENOM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd7;

	// Register reset values
	localparam logic              RST_ENABLE = 1'b1;
	localparam logic [THR_W-1:0]  RST_THRESH = 15'd4;
	localparam logic [GAIN_W-1:0] RST_NUMER  = 8'd2;
	localparam logic [GAIN_W-1:0] RST_DENOM  = 8'd1;
	localparam logic [REG_W-1:0]  RST_LEFT   = 12'd0;
	localparam logic [REG_W-1:0]  RST_RIGHT  = 12'd4095;
	localparam logic [REG_W-1:0]  RST_TOP    = 12'd0;
	localparam logic [REG_W-1:0]  RST_BOTTOM = 12'd4095;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_MUL,
		S_DIV,
		S_ADJ,
		S_CLAMP,
		S_OUT
	} state_t;

	// Divider handshake toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ptracl_evt_if.sv =====
// Axis event channel: valid/ready plus event payload.
// Depends on ptracl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ptracl_evt_if;
	import ptracl_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [KIND_W-1:0]       value_kind;
	logic [AXIS_W-1:0]       axis_select;
	logic signed [VAL_W-1:0] axis_value;

	modport source (output valid, value_kind, axis_select, axis_value, input ready);
	modport sink   (input valid, value_kind, axis_select, axis_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ptracl_res_if.sv =====
// Result channel: valid/ready plus cursor, step and wheel payload.
// Depends on ptracl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ptracl_res_if;
	import ptracl_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OUT_POS_W-1:0]     cursor_x;
	logic [OUT_POS_W-1:0]     cursor_y;
	logic signed [STEP_W-1:0] step_dx;
	logic signed [STEP_W-1:0] step_dy;
	logic                     moved;
	logic                     wheel_valid;
	logic signed [VAL_W-1:0]  wheel_step;

	modport source (output valid, cursor_x, cursor_y, step_dx, step_dy, moved, wheel_valid,
		wheel_step, input ready);
	modport sink   (input valid, cursor_x, cursor_y, step_dx, step_dy, moved, wheel_valid,
		wheel_step, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ptracl_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle (unsigned).
// Depends on ptracl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptracl_div (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  wire [ptracl_pkg::PROD_W-1:0]      dividend,
	input  wire [ptracl_pkg::GAIN_W-1:0]      divisor,
	output ptracl_pkg::div_stat_t             stat,
	output logic [ptracl_pkg::PROD_W-1:0]     quotient
);
	import ptracl_pkg::*;

	localparam int CNT_W = $clog2(PROD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [GAIN_W-1:0] rem_q;
	logic [GAIN_W-1:0] dvs_q;
	logic [PROD_W-1:0] quo_q;

	logic [GAIN_W:0]   shifted;
	logic [GAIN_W:0]   trial;
	logic              fits;

	always_comb begin
		shifted = {rem_q, quo_q[PROD_W-1]};
		trial   = shifted - {1'b0, dvs_q};
		fits    = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[GAIN_W-1:0] : shifted[GAIN_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/core/pointer_accel_clamp_unit.sv =====
// Pointer axis event unit: acceleration, absolute-to-delta, clamped cursor, wheel step.
// Sequence: wheel and ignored events go IDLE, PREP, OUT; clamped x/y motion adds CLAMP;
//   an accelerated relative x/y delta adds MUL, DIV (24-step serial divider), ADJ and CLAMP.
// Flow: one event at a time; input is ready again the cycle after the result is
//   registered, and later while a held result waits on res.ready.
// Reset (arst_n, async): cursor at 0,0, registers at defaults, no result pending.
// Depends on ptracl_pkg, ptracl_evt_if, ptracl_res_if, ptracl_div.
`timescale 1ns / 1ps
`default_nettype none

module pointer_accel_clamp_unit #(
	parameter int COORD_BITS = ptracl_pkg::COORD_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [ptracl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [ptracl_pkg::CFG_DATA_W-1:0]   cfg_data,
	ptracl_evt_if.sink                         evt,
	ptracl_res_if.source                       res
);
	import ptracl_pkg::*;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic                  enable_q;
	logic [THR_W-1:0]      thr_q;
	logic [GAIN_W-1:0]     num_q;
	logic [GAIN_W-1:0]     den_q;
	logic [COORD_BITS-1:0] left_q, right_q, top_q, bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= RST_ENABLE;
			thr_q    <= RST_THRESH;
			num_q    <= RST_NUMER;
			den_q    <= RST_DENOM;
			left_q   <= COORD_BITS'(RST_LEFT);
			right_q  <= COORD_BITS'(RST_RIGHT);
			top_q    <= COORD_BITS'(RST_TOP);
			bottom_q <= COORD_BITS'(RST_BOTTOM);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE: enable_q <= cfg_data[0];
				CFG_THRESH: thr_q    <= cfg_data[THR_W-1:0];
				CFG_NUMER:  num_q    <= cfg_data[GAIN_W-1:0];
				CFG_DENOM:  den_q    <= cfg_data[GAIN_W-1:0];
				CFG_LEFT:   left_q   <= COORD_BITS'(cfg_data[REG_W-1:0]);
				CFG_RIGHT:  right_q  <= COORD_BITS'(cfg_data[REG_W-1:0]);
				CFG_TOP:    top_q    <= COORD_BITS'(cfg_data[REG_W-1:0]);
				CFG_BOTTOM: bottom_q <= COORD_BITS'(cfg_data[REG_W-1:0]);
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sequencer
	//   IDLE  -> take one event
	//   PREP  -> classify, |delta| vs threshold, or absolute delta
	//   MUL   -> (|delta| - thr) * num, start divider
	//   DIV   -> wait for quotient (24 divider steps)
	//   ADJ   -> delta = rel +/- quotient
	//   CLAMP -> both axes: min with right/bottom, then max with left/top
	//   OUT   -> load the result register when it is free
	// ---------------------------------------------------------------
	state_t state_q, state_d;

	logic                    ready_c;
	logic                    div_start_c;
	logic                    out_load_c;

	// Item registers
	logic [KIND_W-1:0]       kind_q;
	logic [AXIS_W-1:0]       axis_q;
	logic signed [VAL_W-1:0] val_q;
	logic                    motion_q;
	logic                    wheel_q;
	logic                    accel_q;
	logic [DIFF_W-1:0]       over_q;
	logic signed [ACC_W-1:0] delta_q;
	logic [COORD_BITS-1:0]   nx_q, ny_q;

	// Cursor state
	logic [COORD_BITS-1:0]   pos_x_q, pos_y_q;

	// Result register
	logic                     out_valid_q;
	logic [OUT_POS_W-1:0]     out_x_q, out_y_q;
	logic signed [STEP_W-1:0] out_dx_q, out_dy_q;
	logic                     out_moved_q;
	logic                     out_wvalid_q;
	logic signed [VAL_W-1:0]  out_wstep_q;

	// Divider
	div_stat_t         div_stat;
	logic [PROD_W-1:0] quotient;
	logic [PROD_W-1:0] product;
	logic [GAIN_W-1:0] den_eff;

	// PREP classification
	logic                    prep_rel, prep_abs, prep_xy;
	logic                    prep_motion, prep_wheel, prep_accel;
	logic signed [MAG_W-1:0] val_ext;
	logic [MAG_W-1:0]        mag;
	logic [MAG_W-1:0]        mag_over;
	logic [COORD_BITS-1:0]   pos_sel;
	logic signed [ACC_W-1:0] abs_delta;

	// A zero denominator divides by one
	assign den_eff = (den_q == '0) ? GAIN_W'(1) : den_q;
	assign product = PROD_W'(over_q) * PROD_W'(num_q);

	ptracl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_c),
		.dividend (product),
		.divisor  (den_eff),
		.stat     (div_stat),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		ready_c     = 1'b0;
		div_start_c = 1'b0;
		out_load_c  = 1'b0;
		case (state_q)
			S_IDLE: begin
				ready_c = 1'b1;
				if (evt.valid) state_d = S_PREP;
			end
			S_PREP: begin
				// decisions use the values classified in this cycle
				if (prep_accel)       state_d = S_MUL;
				else if (prep_motion) state_d = S_CLAMP;
				else                  state_d = S_OUT;
			end
			S_MUL: begin
				div_start_c = 1'b1;
				state_d     = S_DIV;
			end
			S_DIV: begin
				if (div_stat.done) state_d = S_ADJ;
			end
			S_ADJ:   state_d = S_CLAMP;
			S_CLAMP: state_d = S_OUT;
			S_OUT: begin
				if (!out_valid_q || res.ready) begin
					out_load_c = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign evt.ready = ready_c;

	// ---------------------------------------------------------------
	// PREP: classification and threshold test
	// ---------------------------------------------------------------
	always_comb begin
		prep_rel    = enable_q && (kind_q == KIND_REL);
		prep_abs    = enable_q && (kind_q == KIND_ABS);
		prep_xy     = (axis_q == AXIS_X) || (axis_q == AXIS_Y);
		prep_motion = (prep_rel || prep_abs) && prep_xy;
		prep_wheel  = prep_rel && (axis_q == AXIS_Z);
		val_ext     = MAG_W'(val_q);
		mag         = val_q[VAL_W-1] ? MAG_W'(-val_ext) : MAG_W'(val_ext);
		prep_accel  = prep_rel && prep_xy && (mag > MAG_W'(thr_q));
		mag_over    = mag - MAG_W'(thr_q);
		pos_sel     = (axis_q == AXIS_X) ? pos_x_q : pos_y_q;
		abs_delta   = ACC_W'(val_q) - $signed(ACC_W'(pos_sel));
	end

	// ---------------------------------------------------------------
	// CLAMP: new = min(cur + d, hi), then max(.., lo); lower bound wins
	// when the region is inverted
	// ---------------------------------------------------------------
	function automatic logic signed [ACC_W-1:0] clamp_axis(
		input logic signed [ACC_W-1:0] cur,
		input logic signed [ACC_W-1:0] d,
		input logic signed [ACC_W-1:0] lo,
		input logic signed [ACC_W-1:0] hi
	);
		logic signed [ACC_W-1:0] n;
		n = cur + d;
		if (n > hi) n = hi;
		if (n < lo) n = lo;
		return n;
	endfunction

	logic signed [ACC_W-1:0] dx_c, dy_c, nx_c, ny_c;
	logic signed [ACC_W-1:0] adj_q_ext;

	always_comb begin
		dx_c = (axis_q == AXIS_X) ? delta_q : '0;
		dy_c = (axis_q == AXIS_Y) ? delta_q : '0;
		nx_c = clamp_axis($signed(ACC_W'(pos_x_q)), dx_c,
			$signed(ACC_W'(left_q)), $signed(ACC_W'(right_q)));
		ny_c = clamp_axis($signed(ACC_W'(pos_y_q)), dy_c,
			$signed(ACC_W'(top_q)), $signed(ACC_W'(bottom_q)));
		// truncating division: apply the quotient with the sign of the delta
		adj_q_ext = $signed(ACC_W'(quotient));
	end

	// ---------------------------------------------------------------
	// OUT: result fields
	// ---------------------------------------------------------------
	logic                    moved_c;
	logic signed [ACC_W-1:0] sdx_c, sdy_c;
	logic signed [VAL_W-1:0] wstep_c;

	always_comb begin
		moved_c = motion_q && ((nx_q != pos_x_q) || (ny_q != pos_y_q));
		sdx_c   = $signed(ACC_W'(nx_q)) - $signed(ACC_W'(pos_x_q));
		sdy_c   = $signed(ACC_W'(ny_q)) - $signed(ACC_W'(pos_y_q));
		// -(-32768) saturates to the largest positive step
		if (val_q == {1'b1, {(VAL_W-1){1'b0}}}) wstep_c = {1'b0, {(VAL_W-1){1'b1}}};
		else                                   wstep_c = -val_q;
	end

	// Item datapath (payload, no reset)
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (evt.valid) begin
					kind_q <= evt.value_kind;
					axis_q <= evt.axis_select;
					val_q  <= evt.axis_value;
				end
			end
			S_PREP: begin
				motion_q <= prep_motion;
				wheel_q  <= prep_wheel;
				accel_q  <= prep_accel;
				over_q   <= mag_over[DIFF_W-1:0];
				delta_q  <= prep_abs ? abs_delta : ACC_W'(val_q);
			end
			S_ADJ: begin
				delta_q <= val_q[VAL_W-1] ? (ACC_W'(val_q) - adj_q_ext)
				                          : (ACC_W'(val_q) + adj_q_ext);
			end
			S_CLAMP: begin
				nx_q <= COORD_BITS'(nx_c);
				ny_q <= COORD_BITS'(ny_c);
			end
			default: ;
		endcase
	end

	// Cursor position and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load_c) begin
				out_valid_q <= 1'b1;
				if (moved_c) begin
					pos_x_q <= nx_q;
					pos_y_q <= ny_q;
				end
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (out_load_c) begin
			out_x_q      <= OUT_POS_W'(moved_c ? nx_q : pos_x_q);
			out_y_q      <= OUT_POS_W'(moved_c ? ny_q : pos_y_q);
			out_dx_q     <= moved_c ? STEP_W'(sdx_c) : '0;
			out_dy_q     <= moved_c ? STEP_W'(sdy_c) : '0;
			out_moved_q  <= moved_c;
			out_wvalid_q <= wheel_q;
			out_wstep_q  <= wheel_q ? wstep_c : '0;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.cursor_x    = out_x_q;
	assign res.cursor_y    = out_y_q;
	assign res.step_dx     = out_dx_q;
	assign res.step_dy     = out_dy_q;
	assign res.moved       = out_moved_q;
	assign res.wheel_valid = out_wvalid_q;
	assign res.wheel_step  = out_wstep_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// A result never reports both cursor motion and a wheel step
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.moved && res.wheel_valid))
		else $error("motion and wheel reported together");

	// A moved result carries a nonzero step on some axis
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.moved) |-> ((res.step_dx != '0) || (res.step_dy != '0)))
		else $error("moved flag without a step");

	// The divider finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV))
		else $error("divider done outside the divide wait");

	// Accelerated path only for relative x/y events
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (accel_q && motion_q && !wheel_q))
		else $error("multiply step without an accelerated motion");

	// One event in flight: input closes after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && evt.ready) |=> !evt.ready)
		else $error("second event taken while busy");

endmodule

`default_nettype wire

// ===== test/pointer_accel_clamp_unit_test.sv =====
// Self-checking testbench for pointer_accel_clamp_unit: a directed table, then random traffic.
// Each result is compared with the tracker's report, or with the report typed in its table row.
// Depends on ptracl_pkg, ptracl_evt_if, ptracl_res_if and the unit itself.
`timescale 1ns / 1ps

module pointer_accel_clamp_unit_test;
	import ptracl_pkg::*;

	// Event codes the package leaves out: all three are ignored by the block
	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;
	localparam logic [AXIS_W-1:0] AXIS_OTHER = 2'd3;

	localparam int RAND_PHASES = 8;

	// One result transfer, field for field
	typedef struct packed {
		logic [OUT_POS_W-1:0]     cursor_x;
		logic [OUT_POS_W-1:0]     cursor_y;
		logic signed [STEP_W-1:0] step_dx;
		logic signed [STEP_W-1:0] step_dy;
		logic                     moved;
		logic                     wheel_valid;
		logic signed [VAL_W-1:0]  wheel_step;
	} cursor_report_t;

	// Row of the directed table: either a register write or an event.
	// For an event, 'typed' means the expected report is spelled out in the row.
	typedef struct {
		bit                      is_write;
		logic [CFG_IDX_W-1:0]    reg_idx;
		logic [CFG_DATA_W-1:0]   reg_val;
		logic [KIND_W-1:0]       kind;
		logic [AXIS_W-1:0]       axis;
		logic signed [VAL_W-1:0] value;
		bit                      typed;
		cursor_report_t          want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ptracl_evt_if evt_bus ();
	ptracl_res_if res_bus ();

	pointer_accel_clamp_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.evt      (evt_bus),
		.res      (res_bus)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Tracker state: the cursor and a shadow of every register
	logic [OUT_POS_W-1:0] cur_x, cur_y;
	logic                 en_r;
	logic [THR_W-1:0]     thresh_r;
	logic [GAIN_W-1:0]    numer_r, denom_r;
	logic [REG_W-1:0]     left_r, right_r, top_r, bottom_r;

	cursor_report_t expected_reports[$];
	stim_row_t      directed_rows[$];

	// Percent of cycles the sender sits idle / the receiver holds ready low
	int src_idle_pct  = 0;
	int sink_stall_pct = 0;
	bit failed = 1'b0;

	// Gain stage: only the part of the delta past the threshold is scaled.
	// SV signed division truncates toward zero, same as the block is meant to.
	function automatic longint boost(longint rel);
		longint t, n, d;
		t = thresh_r;
		n = numer_r;
		d = (denom_r == 0) ? 1 : denom_r;  // zero denominator behaves as one
		if (rel > t)
			rel = rel + (rel - t) * n / d;
		else if (rel < -t)
			rel = rel + (rel + t) * n / d;
		return rel;
	endfunction

	// Upper bound first, lower bound last: an inverted region lands on lo
	function automatic longint fit(longint n, longint lo, longint hi);
		if (n > hi) n = hi;
		if (n < lo) n = lo;
		return n;
	endfunction

	// Advance the tracked cursor by one accepted event and return its report
	function automatic cursor_report_t step_cursor(logic [KIND_W-1:0] kind,
		logic [AXIS_W-1:0] axis, logic signed [VAL_W-1:0] value);
		cursor_report_t r;
		longint v, px, py, dx, dy, nx, ny, ws;
		bit motion;
		r = '0;
		v = value;
		px = cur_x;
		py = cur_y;
		dx = 0;
		dy = 0;
		motion = 1'b0;
		if (en_r && kind == KIND_REL) begin
			if (axis == AXIS_X) begin
				dx = boost(v);
				motion = 1'b1;
			end else if (axis == AXIS_Y) begin
				dy = boost(v);
				motion = 1'b1;
			end else if (axis == AXIS_Z) begin
				// wheel runs opposite to the axis; -(-32768) saturates
				ws = -v;
				if (ws > 32767) ws = 32767;
				r.wheel_valid = 1'b1;
				r.wheel_step  = ws;
			end
		end else if (en_r && kind == KIND_ABS) begin
			if (axis == AXIS_X) begin
				dx = v - px;
				motion = 1'b1;
			end else if (axis == AXIS_Y) begin
				dy = v - py;
				motion = 1'b1;
			end
		end
		if (motion) begin
			// both axes are clamped, even the one that did not move
			nx = fit(px + dx, left_r, right_r);
			ny = fit(py + dy, top_r, bottom_r);
			if (nx != px || ny != py) begin
				r.step_dx = nx - px;
				r.step_dy = ny - py;
				r.moved   = 1'b1;
				cur_x = nx;
				cur_y = ny;
			end
		end
		r.cursor_x = cur_x;
		r.cursor_y = cur_y;
		return r;
	endfunction

	function automatic cursor_report_t rpt(int cx, int cy, int dx, int dy, bit mv, bit wv,
		int ws);
		cursor_report_t r;
		r.cursor_x    = cx;
		r.cursor_y    = cy;
		r.step_dx     = dx;
		r.step_dy     = dy;
		r.moved       = mv;
		r.wheel_valid = wv;
		r.wheel_step  = ws;
		return r;
	endfunction

	// Directed table builders
	function automatic void row_write(logic [CFG_IDX_W-1:0] idx, int val);
		stim_row_t s;
		s = '{default: '0};
		s.is_write = 1'b1;
		s.reg_idx  = idx;
		s.reg_val  = val;
		directed_rows.push_back(s);
	endfunction

	function automatic void row_known(logic [KIND_W-1:0] kind, logic [AXIS_W-1:0] axis,
		int value, bit typed, cursor_report_t want);
		stim_row_t s;
		s = '{default: '0};
		s.kind  = kind;
		s.axis  = axis;
		s.value = value;
		s.typed = typed;
		s.want  = want;
		directed_rows.push_back(s);
	endfunction

	function automatic void row_event(logic [KIND_W-1:0] kind, logic [AXIS_W-1:0] axis,
		int value);
		row_known(kind, axis, value, 1'b0, '0);
	endfunction

	// Register write: cfg_we goes low again before the task returns, so cfg_we never gets two updates in one step
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_ENABLE: en_r     = val[0];
			CFG_THRESH: thresh_r = val[THR_W-1:0];
			CFG_NUMER:  numer_r  = val[GAIN_W-1:0];
			CFG_DENOM:  denom_r  = val[GAIN_W-1:0];
			CFG_LEFT:   left_r   = val[REG_W-1:0];
			CFG_RIGHT:  right_r  = val[REG_W-1:0];
			CFG_TOP:    top_r    = val[REG_W-1:0];
			CFG_BOTTOM: bottom_r = val[REG_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid and hold off until every report is back, then leave the bus idle before returning
	task automatic drain();
		evt_bus.valid <= 1'b0;
		do @(posedge clk); while (expected_reports.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// One event transfer; the tracker advances at the edge where it is taken
	task automatic send_event(logic [KIND_W-1:0] kind, logic [AXIS_W-1:0] axis,
		logic signed [VAL_W-1:0] value, bit typed, cursor_report_t want);
		cursor_report_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			evt_bus.valid <= 1'b0;
			@(posedge clk);
		end
		evt_bus.valid       <= 1'b1;
		evt_bus.value_kind  <= kind;
		evt_bus.axis_select <= axis;
		evt_bus.axis_value  <= value;
		@(posedge clk);
		while (!evt_bus.ready) @(posedge clk);
		predicted = step_cursor(kind, axis, value);
		expected_reports.push_back(typed ? want : predicted);
	endtask

	// Random relative delta: mostly around the threshold, where the gain kicks in
	function automatic logic signed [VAL_W-1:0] rand_delta();
		int sel;
		logic signed [VAL_W-1:0] d;
		sel = $urandom_range(9);
		if (sel < 5)
			d = int'(thresh_r) + $urandom_range(8) - 4;
		else if (sel < 8)
			d = $urandom_range(64) - 32;
		else if (sel == 8)
			d = $urandom;
		else
			d = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		if (sel < 5 && $urandom_range(1)) d = -d;
		return d;
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_coord();
		int sel;
		sel = $urandom_range(9);
		if (sel < 7) return $urandom_range(4095);
		if (sel < 9) return $urandom;
		return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
	endfunction

	// Random region bounds, usually ordered, now and then inverted
	task automatic rand_bounds(logic [CFG_IDX_W-1:0] lo_idx, logic [CFG_IDX_W-1:0] hi_idx);
		logic [REG_W-1:0] a, b, t;
		a = $urandom;
		b = $urandom;
		if (a > b && $urandom_range(4) != 0) begin
			t = a;
			a = b;
			b = t;
		end
		write_reg(lo_idx, a);
		write_reg(hi_idx, b);
	endtask

	// Settings per random phase; the first ones pin the extremes
	task automatic set_phase(int k);
		case (k)
			0: begin
				write_reg(CFG_THRESH, 0);
				write_reg(CFG_NUMER, 255);
				write_reg(CFG_DENOM, 1);
			end
			1: begin
				// no acceleration at all, cursor pinned to one corner
				write_reg(CFG_THRESH, 15'h7fff);
				write_reg(CFG_NUMER, 0);
				write_reg(CFG_DENOM, 255);
				write_reg(CFG_LEFT, 4095);
				write_reg(CFG_RIGHT, 4095);
				write_reg(CFG_TOP, 0);
				write_reg(CFG_BOTTOM, 0);
			end
			2: write_reg(CFG_ENABLE, 0);
			3: begin
				write_reg(CFG_ENABLE, 1);
				write_reg(CFG_THRESH, 8);
				write_reg(CFG_NUMER, 3);
				write_reg(CFG_DENOM, 2);
				write_reg(CFG_LEFT, 0);
				write_reg(CFG_RIGHT, 4095);
				write_reg(CFG_TOP, 0);
				write_reg(CFG_BOTTOM, 4095);
			end
			default: begin
				write_reg(CFG_THRESH,
					($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(40));
				write_reg(CFG_NUMER, $urandom_range(255));
				write_reg(CFG_DENOM, $urandom_range(255, 1));
				rand_bounds(CFG_LEFT, CFG_RIGHT);
				rand_bounds(CFG_TOP, CFG_BOTTOM);
			end
		endcase
	endtask

	// Mostly real x/y motion and wheel steps; the rest is traffic the block ignores
	task automatic send_random_event();
		int pick;
		logic [KIND_W-1:0] kind;
		logic [AXIS_W-1:0] axis;
		logic signed [VAL_W-1:0] value;
		pick = $urandom_range(99);
		if (pick < 62) begin
			kind  = ($urandom_range(99) < 65) ? KIND_REL : KIND_ABS;
			axis  = $urandom_range(1) ? AXIS_Y : AXIS_X;
			value = (kind == KIND_REL) ? rand_delta() : rand_coord();
		end else if (pick < 80) begin
			kind  = KIND_REL;
			axis  = AXIS_Z;
			value = rand_delta();
		end else begin
			case ($urandom_range(2))
				0: begin
					kind = $urandom_range(1) ? KIND_RSVD : KIND_NONE;
					axis = $urandom_range(3);
				end
				1: begin
					kind = $urandom_range(1) ? KIND_ABS : KIND_REL;
					axis = AXIS_OTHER;
				end
				default: begin
					kind = KIND_ABS;
					axis = AXIS_Z;
				end
			endcase
			value = $urandom;
		end
		send_event(kind, axis, value, 1'b0, '0);
	endtask

	task automatic diff(string name, logic signed [31:0] want, logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endtask

	// Result side: compare each transfer with the oldest pending report,
	// then pick ready for the next cycle
	always @(posedge clk) begin
		cursor_report_t want;
		if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			if (expected_reports.size() == 0) begin
				$error("result transfer with no event pending");
				failed = 1'b1;
			end else begin
				want = expected_reports.pop_front();
				diff("cursor_x", want.cursor_x, res_bus.cursor_x);
				diff("cursor_y", want.cursor_y, res_bus.cursor_y);
				diff("step_dx", want.step_dx, res_bus.step_dx);
				diff("step_dy", want.step_dy, res_bus.step_dy);
				diff("moved", want.moved, res_bus.moved);
				diff("wheel_valid", want.wheel_valid, res_bus.wheel_valid);
				diff("wheel_step", want.wheel_step, res_bus.wheel_step);
			end
		end
		res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	initial begin
		int n_items;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		evt_bus.valid       = 1'b0;
		evt_bus.value_kind  = '0;
		evt_bus.axis_select = '0;
		evt_bus.axis_value  = '0;
		res_bus.ready       = 1'b0;

		// Tracker starts from the documented reset state
		cur_x    = '0;
		cur_y    = '0;
		en_r     = RST_ENABLE;
		thresh_r = RST_THRESH;
		numer_r  = RST_NUMER;
		denom_r  = RST_DENOM;
		left_r   = RST_LEFT;
		right_r  = RST_RIGHT;
		top_r    = RST_TOP;
		bottom_r = RST_BOTTOM;

		// Directed table, reset defaults: threshold 4, gain 2/1, full region.
		// Typed rows are the ones readable by eye; the rest go through the tracker.
		//         kind       axis        value   typed  x     y     dx     dy    mv wv wheel
		row_known(KIND_REL,  AXIS_X,      0,      1, rpt(0,    0,    0,     0,    0, 0, 0));
		row_known(KIND_ABS,  AXIS_X,      100,    1, rpt(100,  0,    100,   0,    1, 0, 0));
		row_event(KIND_REL,  AXIS_X,      3);      // under threshold
		row_event(KIND_REL,  AXIS_X,      4);      // exactly at threshold, no gain
		row_event(KIND_REL,  AXIS_X,      5);      // one past threshold
		row_event(KIND_REL,  AXIS_X,      -5);
		row_known(KIND_REL,  AXIS_Y,      32767,  1, rpt(107,  4095, 0,     4095, 1, 0, 0));
		row_known(KIND_REL,  AXIS_Y,      -32768, 1, rpt(107,  0,    0,    -4095, 1, 0, 0));
		row_known(KIND_ABS,  AXIS_Y,      -32768, 1, rpt(107,  0,    0,     0,    0, 0, 0));
		row_known(KIND_ABS,  AXIS_X,      32767,  1, rpt(4095, 0,    3988,  0,    1, 0, 0));
		row_known(KIND_ABS,  AXIS_Y,      4095,   1, rpt(4095, 4095, 0,     4095, 1, 0, 0));
		row_known(KIND_REL,  AXIS_Z,      5,      1, rpt(4095, 4095, 0,     0,    0, 1, -5));
		row_known(KIND_REL,  AXIS_Z,      -32768, 1, rpt(4095, 4095, 0,     0,    0, 1, 32767));
		row_known(KIND_REL,  AXIS_Z,      32767,  1, rpt(4095, 4095, 0,     0,    0, 1, -32767));
		row_known(KIND_REL,  AXIS_Z,      0,      1, rpt(4095, 4095, 0,     0,    0, 1, 0));
		// ignored: absolute wheel, unused kinds, unused axis
		row_known(KIND_ABS,  AXIS_Z,      100,    1, rpt(4095, 4095, 0,     0,    0, 0, 0));
		row_known(KIND_NONE, AXIS_X,      100,    1, rpt(4095, 4095, 0,     0,    0, 0, 0));
		row_known(KIND_RSVD, AXIS_Y,      -100,   1, rpt(4095, 4095, 0,     0,    0, 0, 0));
		row_known(KIND_REL,  AXIS_OTHER,  100,    1, rpt(4095, 4095, 0,     0,    0, 0, 0));
		row_known(KIND_ABS,  AXIS_X,      0,      1, rpt(0,    4095, -4095, 0,    1, 0, 0));
		row_event(KIND_REL,  AXIS_Y,      -6);
		// cursor disabled: motion is dropped
		row_write(CFG_ENABLE, 0);
		row_event(KIND_REL,  AXIS_X,      50);
		row_write(CFG_ENABLE, 1);
		// zero denominator counts as one; then a quotient that must truncate toward zero
		row_write(CFG_DENOM, 0);
		row_event(KIND_REL,  AXIS_X,      100);
		row_write(CFG_DENOM, 3);
		row_event(KIND_REL,  AXIS_X,      -9);
		// inverted x range; a zero y delta still pulls x onto the left bound
		row_write(CFG_LEFT, 3000);
		row_write(CFG_RIGHT, 1000);
		row_event(KIND_REL,  AXIS_Y,      0);
		row_write(CFG_LEFT, 0);
		row_write(CFG_RIGHT, 4095);
		row_write(CFG_DENOM, 1);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct   = 37;
		sink_stall_pct = 37;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				drain();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				send_event(directed_rows[i].kind, directed_rows[i].axis,
					directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// Random phases: new settings on an idle block, then a rotating idle pattern
		for (int k = 0; k < RAND_PHASES; k++) begin
			drain();
			set_phase(k);
			case (k % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 57; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 57; end
				default: begin src_idle_pct = 37; sink_stall_pct = 37; end
			endcase
			n_items = (k == 2) ? 20 : 83;  // disabled phase stays short
			for (int j = 0; j < n_items; j++) begin
				// now and then let the pipeline run dry before the next transfer
				if ($urandom_range(49) == 0) drain();
				send_random_event();
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (!failed)
			$display("[pointer_accel_clamp_unit] OK");
		else
			$display("[pointer_accel_clamp_unit] ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#2000000;
		$display("[pointer_accel_clamp_unit] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ptracl_pkg.sv
rtl/core/ptracl_evt_if.sv
rtl/core/ptracl_res_if.sv
rtl/core/ptracl_div.sv
rtl/core/pointer_accel_clamp_unit.sv
test/pointer_accel_clamp_unit_test.sv
